// ===== rtl/dpf_pkg.sv =====
// shared constants for the demand paging fifo translator
package dpf_pkg;

   localparam int PAGE_COUNT_DEFAULT  = 256;
   localparam int OFFSET_BITS_DEFAULT = 8;

   localparam int ADDR_W      = 16;
   localparam int FRAME_BITS  = 8;
   localparam int FRAME_SLOTS = 256;
   localparam int FC_W        = 9;
   localparam int FAULT_W     = 32;
   localparam int EV_PAGE_W   = 8;

   localparam logic [FC_W-1:0] FRAME_COUNT_RESET = 9'd256;

endpackage

// ===== rtl/demand_paging_fifo_translator_core.sv =====
// demand paging address translator with fifo frame replacement
// sequence: idle, lookup, decide; a hit strobes its result from decide, a fault goes on to
//   update first (div_mul and div_sub reduce the page number before lookup when PAGE_COUNT is not a power of two)
// throughput: one transaction at a time, busy until decide on a hit, until the page table write-back on a fault
// reset: a clearing pass over max(PAGE_COUNT, 256) entries sweeps the page table and
//   frame owner rams; busy stays high meanwhile. results are never stalled
module demand_paging_fifo_translator_core
   import dpf_pkg::*;
#(
   parameter int PAGE_COUNT  = PAGE_COUNT_DEFAULT,
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [ADDR_W-1:0]    req_logical_address,
   input  logic                 csr_write_enable,
   input  logic [FC_W-1:0]      csr_frame_count,
   output logic                 rsp_valid,
   output logic [ADDR_W-1:0]    rsp_physical_address,
   output logic                 rsp_page_fault,
   output logic                 rsp_evicted_valid,
   output logic [EV_PAGE_W-1:0] rsp_evicted_page,
   output logic [FAULT_W-1:0]   rsp_fault_total
);

   localparam int PAGE_BITS   = $clog2(PAGE_COUNT);
   localparam bit PC_POW2     = (PAGE_COUNT & (PAGE_COUNT - 1)) == 0;
   localparam int CLEAR_DEPTH = (PAGE_COUNT > FRAME_SLOTS) ? PAGE_COUNT : FRAME_SLOTS;
   localparam int CLR_W       = $clog2(CLEAR_DEPTH);
   localparam int PT_W        = 1 + FRAME_BITS;
   localparam int OWN_W       = 1 + PAGE_BITS;
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_W     = 17;
   localparam int QUOT_W      = ADDR_W + RECIP_W - RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_SHIFT) / PAGE_COUNT);
   localparam logic [ADDR_W-1:0]  OFF_MASK = ADDR_W'((1 << OFFSET_BITS) - 1);

   localparam logic [2:0] ST_CLEAR   = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_DIV_MUL = 3'd2;
   localparam logic [2:0] ST_DIV_SUB = 3'd3;
   localparam logic [2:0] ST_LOOKUP  = 3'd4;
   localparam logic [2:0] ST_DECIDE  = 3'd5;
   localparam logic [2:0] ST_UPDATE  = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic [CLR_W-1:0]     clr_ff, clr_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic [QUOT_W-1:0]    quot_ff, quot_in;
   logic [FRAME_BITS-1:0] next_frame_ff, next_frame_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic                 all_used_ff, all_used_in;
   logic [FAULT_W-1:0]   fault_cnt_ff, fault_cnt_in;
   logic [FC_W-1:0]      frame_count_ff, frame_count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]    rsp_phys_ff, rsp_phys_in;
   logic                 rsp_fault_ff, rsp_fault_in;
   logic                 rsp_ev_valid_ff, rsp_ev_valid_in;
   logic [EV_PAGE_W-1:0] rsp_ev_page_ff, rsp_ev_page_in;

   logic                 pt_wr_en;
   logic [PAGE_BITS-1:0] pt_wr_addr;
   logic [PT_W-1:0]      pt_wr_data;
   logic [PT_W-1:0]      pt_rd_data;
   logic                 own_wr_en;
   logic [FRAME_BITS-1:0] own_wr_addr;
   logic [OWN_W-1:0]     own_wr_data;
   logic [OWN_W-1:0]     own_rd_data;

   logic [ADDR_W-1:0]    req_raw;
   logic [ADDR_W-1:0]    addr_raw;
   logic [31:0]          rem_wide;
   logic [31:0]          rem_fix;
   logic                 hit;
   logic                 evict;
   logic [FRAME_BITS-1:0] frame_sel;
   logic [FC_W-1:0]      eff_frames;
   logic [FC_W-1:0]      nf_plus;
   logic [31:0]          phys_wide;
   logic                 accept;

   dpf_ram #(.WIDTH(PT_W), .DEPTH(PAGE_COUNT)) u_page_table (
      .clock   (clock),
      .wr_en   (pt_wr_en),
      .wr_addr (pt_wr_addr),
      .wr_data (pt_wr_data),
      .rd_addr (page_ff),
      .rd_data (pt_rd_data)
   );

   // frame owner table: which page holds each frame
   dpf_ram #(.WIDTH(OWN_W), .DEPTH(FRAME_SLOTS)) u_frame_owner (
      .clock   (clock),
      .wr_en   (own_wr_en),
      .wr_addr (own_wr_addr),
      .wr_data (own_wr_data),
      .rd_addr (next_frame_ff),
      .rd_data (own_rd_data)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign req_raw  = req_logical_address >> OFFSET_BITS;
   assign addr_raw = addr_ff >> OFFSET_BITS;

   // remainder from the reciprocal quotient, high by at most one page count
   assign rem_wide = 32'(addr_raw) - 32'(quot_ff) * 32'(PAGE_COUNT);
   assign rem_fix  = (rem_wide >= 32'(PAGE_COUNT)) ? rem_wide - 32'(PAGE_COUNT) : rem_wide;

   assign hit       = pt_rd_data[PT_W-1];
   assign evict     = !hit && all_used_ff && own_rd_data[OWN_W-1];
   assign frame_sel = hit ? pt_rd_data[FRAME_BITS-1:0] : next_frame_ff;
   assign phys_wide = (32'(frame_sel) << OFFSET_BITS) | 32'(addr_ff & OFF_MASK);

   always_comb begin
      if (frame_count_ff == '0) begin
         eff_frames = FC_W'(1);
      end else if (frame_count_ff > FC_W'(FRAME_SLOTS)) begin
         eff_frames = FC_W'(FRAME_SLOTS);
      end else begin
         eff_frames = frame_count_ff;
      end
   end

   assign nf_plus = {1'b0, next_frame_ff} + FC_W'(1);

   always_comb begin
      state_in        = state_ff;
      clr_in          = clr_ff;
      addr_in         = addr_ff;
      page_in         = page_ff;
      quot_in         = quot_ff;
      next_frame_in   = next_frame_ff;
      frame_in        = frame_ff;
      all_used_in     = all_used_ff;
      fault_cnt_in    = fault_cnt_ff;
      frame_count_in  = csr_write_enable ? csr_frame_count : frame_count_ff;
      rsp_valid_in    = 1'b0;
      rsp_phys_in     = rsp_phys_ff;
      rsp_fault_in    = rsp_fault_ff;
      rsp_ev_valid_in = rsp_ev_valid_ff;
      rsp_ev_page_in  = rsp_ev_page_ff;
      pt_wr_en        = 1'b0;
      pt_wr_addr      = page_ff;
      pt_wr_data      = '0;
      own_wr_en       = 1'b0;
      own_wr_addr     = next_frame_ff;
      own_wr_data     = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            pt_wr_en    = 32'(clr_ff) < 32'(PAGE_COUNT);
            pt_wr_addr  = clr_ff[PAGE_BITS-1:0];
            own_wr_en   = 32'(clr_ff) < 32'(FRAME_SLOTS);
            own_wr_addr = clr_ff[FRAME_BITS-1:0];
            clr_in      = clr_ff + CLR_W'(1);
            if (32'(clr_ff) == 32'(CLEAR_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               addr_in = req_logical_address;
               page_in = req_raw[PAGE_BITS-1:0];
               state_in = PC_POW2 ? ST_LOOKUP : ST_DIV_MUL;
            end
         end
         ST_DIV_MUL: begin
            quot_in  = QUOT_W'((33'(addr_raw) * 33'(RECIP)) >> RECIP_SHIFT);
            state_in = ST_DIV_SUB;
         end
         ST_DIV_SUB: begin
            page_in  = rem_fix[PAGE_BITS-1:0];
            state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            rsp_phys_in     = phys_wide[ADDR_W-1:0];
            rsp_fault_in    = !hit;
            rsp_ev_valid_in = evict;
            rsp_ev_page_in  = evict ? EV_PAGE_W'(32'(own_rd_data[PAGE_BITS-1:0])) : '0;
            frame_in        = frame_sel;
            if (hit) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               fault_cnt_in = fault_cnt_ff + FAULT_W'(1);
               own_wr_en    = 1'b1;
               own_wr_data  = {1'b1, page_ff};
               // drop the old owner's page table entry
               pt_wr_en     = evict;
               pt_wr_addr   = own_rd_data[PAGE_BITS-1:0];
               if (nf_plus >= eff_frames) begin
                  next_frame_in = '0;
                  all_used_in   = 1'b1;
               end else begin
                  next_frame_in = nf_plus[FRAME_BITS-1:0];
               end
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            pt_wr_en     = 1'b1;
            pt_wr_data   = {1'b1, frame_ff};
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         next_frame_ff  <= '0;
         all_used_ff    <= 1'b0;
         fault_cnt_ff   <= '0;
         frame_count_ff <= FRAME_COUNT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         next_frame_ff  <= next_frame_in;
         all_used_ff    <= all_used_in;
         fault_cnt_ff   <= fault_cnt_in;
         frame_count_ff <= frame_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff         <= addr_in;
      page_ff         <= page_in;
      quot_ff         <= quot_in;
      frame_ff        <= frame_in;
      rsp_phys_ff     <= rsp_phys_in;
      rsp_fault_ff    <= rsp_fault_in;
      rsp_ev_valid_ff <= rsp_ev_valid_in;
      rsp_ev_page_ff  <= rsp_ev_page_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_physical_address = rsp_phys_ff;
   assign rsp_page_fault       = rsp_fault_ff;
   assign rsp_evicted_valid    = rsp_ev_valid_ff;
   assign rsp_evicted_page     = rsp_ev_page_ff;
   assign rsp_fault_total      = fault_cnt_ff;

endmodule

// ===== rtl/dpf_ram.sv =====
// generic single write port ram with registered read
module dpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/tb.sv =====
// testbench for the demand paging fifo translator core: directed and random addresses
module tb;
   import dpf_pkg::*;

   typedef struct packed {
      logic [ADDR_W-1:0]    phys;
      logic                 fault;
      logic                 ev_valid;
      logic [EV_PAGE_W-1:0] ev_page;
      logic [FAULT_W-1:0]   total;
   } translation_type;

   localparam int PAGE_BITS   = ADDR_W - OFFSET_BITS_DEFAULT;
   localparam int MAX_PRINTS  = 40;
   localparam int RAND_PHASES = 12;
   localparam int PHASE_ITEMS = 100;

   // walk through the lowered-count, zero-count and saturated-count cases
   localparam logic [ADDR_W-1:0] DIRECTED_ADDRS[22] = '{
      16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h1234, 16'h12AB, 16'h5555, 16'hAAAA,
      16'h0301, 16'h0402, 16'h0503, 16'h0604, 16'h0000, 16'h0301,
      16'h0710, 16'h0820, 16'h0710,
      16'h0930, 16'h0A40,
      16'h0B00, 16'h0C00, 16'h0B00
   };
   localparam int DIRECTED_CFG_AT[4] = '{8, 14, 17, 19};
   localparam logic [FC_W-1:0] DIRECTED_CFG_VAL[4] = '{9'd2, 9'd0, 9'd511, 9'd1};
   localparam logic [FC_W-1:0] PHASE_FRAME_COUNTS[RAND_PHASES] = '{
      9'd1, 9'd256, 9'd3, 9'd0, 9'd16, 9'd511, 9'd2, 9'd64, 9'd255, 9'd5, 9'd8, 9'd100
   };

   class fifo_paging_scoreboard;
      logic [FRAME_BITS-1:0] frame_of_page [PAGE_COUNT_DEFAULT];
      bit                    page_loaded [PAGE_COUNT_DEFAULT];
      int                    alloc_ptr;
      bit                    frames_wrapped;
      logic [FAULT_W-1:0]    fault_count;
      logic [FC_W-1:0]       frame_count;
      translation_type       translation_q[$];
      int                    mismatches;

      function new();
         foreach (frame_of_page[p]) begin
            frame_of_page[p] = '0;
            page_loaded[p]   = 1'b0;
         end
         alloc_ptr      = 0;
         frames_wrapped = 1'b0;
         fault_count    = '0;
         frame_count    = FRAME_COUNT_RESET;
         mismatches     = 0;
      endfunction

      function int usable_frames();
         if (frame_count == 0) return 1;
         if (frame_count > FRAME_SLOTS) return FRAME_SLOTS;
         return int'(frame_count);
      endfunction

      function int pending();
         return translation_q.size();
      endfunction

      function void set_frame_count(logic [FC_W-1:0] value);
         frame_count = value;
      endfunction

      function void note_request(logic [ADDR_W-1:0] addr);
         int page;
         logic [FRAME_BITS-1:0] frame;
         translation_type t;
         page = int'(addr >> OFFSET_BITS_DEFAULT) % PAGE_COUNT_DEFAULT;
         t = '0;
         if (page_loaded[page]) begin
            frame = frame_of_page[page];
         end else begin
            t.fault = 1'b1;
            fault_count = fault_count + FAULT_W'(1);
            frame = alloc_ptr[FRAME_BITS-1:0];
            // lowest numbered resident owner of the frame gets evicted
            if (frames_wrapped) begin
               for (int p = 0; p < PAGE_COUNT_DEFAULT; p++) begin
                  if (page_loaded[p] && frame_of_page[p] == frame) begin
                     page_loaded[p]   = 1'b0;
                     frame_of_page[p] = '0;
                     t.ev_valid = 1'b1;
                     t.ev_page  = p[EV_PAGE_W-1:0];
                     break;
                  end
               end
            end
            if (alloc_ptr + 1 >= usable_frames()) begin
               alloc_ptr      = 0;
               frames_wrapped = 1'b1;
            end else begin
               alloc_ptr = alloc_ptr + 1;
            end
            page_loaded[page]   = 1'b1;
            frame_of_page[page] = frame;
         end
         t.phys  = {frame, addr[OFFSET_BITS_DEFAULT-1:0]};
         t.total = fault_count;
         translation_q.push_back(t);
      endfunction

      task report_mismatch(string what, logic [FAULT_W-1:0] got, logic [FAULT_W-1:0] want);
         mismatches++;
         if (mismatches <= MAX_PRINTS)
            $display("mismatch @%0t %s: got %0h want %0h", $realtime, what, got, want);
      endtask

      task check_result(translation_type got);
         translation_type want;
         if (translation_q.size() == 0) begin
            report_mismatch("result with no transaction pending", FAULT_W'(got.phys), '0);
            return;
         end
         want = translation_q.pop_front();
         if (got.phys !== want.phys)
            report_mismatch("physical_address", FAULT_W'(got.phys), FAULT_W'(want.phys));
         if (got.fault !== want.fault)
            report_mismatch("page_fault", FAULT_W'(got.fault), FAULT_W'(want.fault));
         if (got.ev_valid !== want.ev_valid)
            report_mismatch("evicted_valid", FAULT_W'(got.ev_valid),
                            FAULT_W'(want.ev_valid));
         if (got.ev_page !== want.ev_page)
            report_mismatch("evicted_page", FAULT_W'(got.ev_page), FAULT_W'(want.ev_page));
         if (got.total !== want.total)
            report_mismatch("fault_total", got.total, want.total);
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [ADDR_W-1:0]    req_logical_address = '0;
   logic                 csr_write_enable = 1'b0;
   logic [FC_W-1:0]      csr_frame_count = '0;
   logic                 rsp_valid;
   logic [ADDR_W-1:0]    rsp_physical_address;
   logic                 rsp_page_fault;
   logic                 rsp_evicted_valid;
   logic [EV_PAGE_W-1:0] rsp_evicted_page;
   logic [FAULT_W-1:0]   rsp_fault_total;

   int sender_idle_pct = 0;
   fifo_paging_scoreboard sb = new();

   demand_paging_fifo_translator_core u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_logical_address  (req_logical_address),
      .csr_write_enable     (csr_write_enable),
      .csr_frame_count      (csr_frame_count),
      .rsp_valid            (rsp_valid),
      .rsp_physical_address (rsp_physical_address),
      .rsp_page_fault       (rsp_page_fault),
      .rsp_evicted_valid    (rsp_evicted_valid),
      .rsp_evicted_page     (rsp_evicted_page),
      .rsp_fault_total      (rsp_fault_total)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result({rsp_physical_address, rsp_page_fault, rsp_evicted_valid,
                          rsp_evicted_page, rsp_fault_total});
   end

   // called right after a rising edge; start stays high on return
   task automatic send_item(input logic [ADDR_W-1:0] addr);
      // each offered cycle is idle with the given percentage
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_logical_address <= addr;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(addr);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0 || busy);
   endtask

   task automatic write_frame_count(input logic [FC_W-1:0] value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_frame_count  <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_frame_count(value);
   endtask

   // mostly a working set a bit larger than the frame pool, some scattered pages
   function automatic logic [ADDR_W-1:0] pick_address(int base, int span);
      logic [PAGE_BITS-1:0] page;
      logic [OFFSET_BITS_DEFAULT-1:0] offset;
      if ($urandom_range(0, 4) == 0)
         page = PAGE_BITS'($urandom_range(0, PAGE_COUNT_DEFAULT - 1));
      else
         page = PAGE_BITS'(base + $urandom_range(0, span));
      offset = OFFSET_BITS_DEFAULT'($urandom_range(0, (1 << OFFSET_BITS_DEFAULT) - 1));
      return {page, offset};
   endfunction

   initial begin
      int cfg_idx;
      int usable;
      int span;
      int base;
      logic [FC_W-1:0] fc;
      cfg_idx = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // reset clearing pass keeps busy high
      do @(posedge clock); while (busy);

      sender_idle_pct = 10;
      foreach (DIRECTED_ADDRS[i]) begin
         if (cfg_idx < 4 && i == DIRECTED_CFG_AT[cfg_idx]) begin
            write_frame_count(DIRECTED_CFG_VAL[cfg_idx]);
            cfg_idx++;
         end
         send_item(DIRECTED_ADDRS[i]);
      end

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         sender_idle_pct = (ph < 4) ? 10 : (ph < 8) ? 71 : 0;
         fc = (ph == RAND_PHASES - 1) ? FC_W'($urandom_range(1, 511)) : PHASE_FRAME_COUNTS[ph];
         write_frame_count(fc);
         usable = sb.usable_frames();
         span = usable + usable / 4 + 1;
         if (span > PAGE_COUNT_DEFAULT - 1) span = PAGE_COUNT_DEFAULT - 1;
         base = $urandom_range(0, PAGE_COUNT_DEFAULT - 1);
         repeat (PHASE_ITEMS) send_item(pick_address(base, span));
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

   initial begin
      #4000000;
      $display("tb NOT OK");
      $finish;
   end

endmodule
